// ===== rtl/core/pic_pkg.sv =====
// Shared types and constants for the proximity item clusterer.
// Used by every module under rtl/core; depends on nothing.
package pic_pkg;

	localparam int ITEM_SLOTS_DEF    = 256;
	localparam int CLUSTER_SLOTS_DEF = 32;

	localparam int COORD_W    = 16;
	localparam int SUP_W      = 10;
	localparam int QIDX_W     = 8;
	localparam int LABEL_W    = 6;
	localparam int MERGED_W   = 5;
	localparam int CTOTAL_W   = 6;
	localparam int ITOTAL_W   = 9;
	localparam int RANGE_W    = 34;
	localparam int LIMIT_W    = 6;
	localparam int CFG_DATA_W = 34;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 32;
	localparam int SQ_W       = 32;
	localparam int DIST_W     = 34;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_RANGE_SQ      = 1'b0,
		REG_CLUSTER_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		RS_JOINED         = 3'd0,
		RS_NEW_CLUSTER    = 3'd1,
		RS_CLUSTERS_FULL  = 3'd2,
		RS_STORE_FULL     = 3'd3,
		RS_QUERY_OK       = 3'd4,
		RS_QUERY_RANGE    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MERGE,
		S_RELAB,
		S_STORE,
		S_QREAD,
		S_RESULT
	} seq_state_t;

	// scan phases: three axes, then the cycle where the full sum is compared
	typedef enum logic [1:0] {
		AX_X   = 2'd0,
		AX_Y   = 2'd1,
		AX_Z   = 2'd2,
		AX_SUM = 2'd3
	} axis_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [SUP_W-1:0]          sup;
	} item_t;

	// control of the shared distance unit
	typedef struct packed {
		axis_t axis;
		logic  clr;
	} dist_ctl_t;

endpackage

// ===== rtl/core/pic_store.sv =====
// Item store: position/support memory and label memory, one write and
// one registered read port each. Depends on pic_pkg.
module pic_store #(
	parameter int ITEM_SLOTS = pic_pkg::ITEM_SLOTS_DEF,
	parameter int LW         = 6
) (
	input  logic                          clk,
	input  logic                          pos_we,
	input  logic [$clog2(ITEM_SLOTS)-1:0] pos_waddr,
	input  pic_pkg::item_t                pos_wdata,
	input  logic [$clog2(ITEM_SLOTS)-1:0] pos_raddr,
	output pic_pkg::item_t                pos_rdata,
	input  logic                          lab_we,
	input  logic [$clog2(ITEM_SLOTS)-1:0] lab_waddr,
	input  logic [LW-1:0]                 lab_wdata,
	input  logic [$clog2(ITEM_SLOTS)-1:0] lab_raddr,
	output logic [LW-1:0]                 lab_rdata
);

	pic_pkg::item_t pos_mem [ITEM_SLOTS];
	logic [LW-1:0]  lab_mem [ITEM_SLOTS];
	pic_pkg::item_t pos_rdata_q;
	logic [LW-1:0]  lab_rdata_q;

	// position and support memory
	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
		pos_rdata_q <= pos_mem[pos_raddr];
	end

	// label memory
	always_ff @(posedge clk) begin
		if (lab_we) begin
			lab_mem[lab_waddr] <= lab_wdata;
		end
		lab_rdata_q <= lab_mem[lab_raddr];
	end

	assign pos_rdata = pos_rdata_q;
	assign lab_rdata = lab_rdata_q;

endmodule

// ===== rtl/core/pic_dist.sv =====
// Shared squared-distance unit: one axis squared per cycle, the three squares
// accumulated and compared against the range. Depends on pic_pkg.
module pic_dist (
	input  logic                            clk,
	input  pic_pkg::dist_ctl_t              ctl,
	input  pic_pkg::item_t                  a,
	input  pic_pkg::item_t                  b,
	input  logic [pic_pkg::RANGE_W-1:0]     range_sq,
	output logic                            near
);

	localparam int ACC_W = pic_pkg::DIST_W - 1;

	logic [pic_pkg::COORD_W-1:0] da, db;
	logic [pic_pkg::COORD_W:0]   diff, mag;
	logic [pic_pkg::SQ_W-1:0]    sq;
	logic [pic_pkg::SQ_W-1:0]    prod_q;
	logic [ACC_W-1:0]            acc_q;
	logic [pic_pkg::DIST_W-1:0]  total;

	// pick the axis for this cycle
	always_comb begin
		case (ctl.axis)
			pic_pkg::AX_X: begin
				da = a.x;
				db = b.x;
			end
			pic_pkg::AX_Y: begin
				da = a.y;
				db = b.y;
			end
			pic_pkg::AX_Z: begin
				da = a.z;
				db = b.z;
			end
			default: begin
				da = a.x;
				db = b.x;
			end
		endcase
	end

	// magnitude of the difference fits 16 bits
	always_comb begin
		diff = {da[pic_pkg::COORD_W-1], da} - {db[pic_pkg::COORD_W-1], db};
		mag  = diff[pic_pkg::COORD_W] ? (~diff + 1'b1) : diff;
		sq   = pic_pkg::SQ_W'(mag[pic_pkg::COORD_W-1:0]) *
		       pic_pkg::SQ_W'(mag[pic_pkg::COORD_W-1:0]);
	end

	// register the square, then accumulate
	always_ff @(posedge clk) begin
		prod_q <= sq;
		acc_q  <= (ctl.clr ? '0 : acc_q) + ACC_W'(prod_q);
	end

	assign total = pic_pkg::DIST_W'(acc_q) + pic_pkg::DIST_W'(prod_q);
	assign near  = (total <= range_sq);

endmodule

// ===== rtl/core/proximity_item_clusterer_top.sv =====
// Top level of the proximity item clusterer: sequencer, cluster hit and
// remap tables. Depends on pic_pkg, pic_store and pic_dist.
//
// channel   | dir | handshake          | payload
// s_        | in  | s_tvalid/s_tready  | s_tuser operation, s_tdata item
// m_        | out | m_tvalid/m_tready  | m_tuser status, m_tdata label, totals
// cfg_      | in  | cfg_we             | cfg_index, cfg_data
//
// An add scans the n stored items in the shared distance unit (one axis
// squared per cycle, then the compare), then the clusters, relabels the items
// when clusters merged and stores the item; a full store goes straight to the result.
// A query reads the stored label unless out of range. Input is taken only in idle;
// a finished word waits in the output register while the next item is accepted.
// Reset clears the counts, loads config defaults; the stores need no clearing pass.
module proximity_item_clusterer_top #(
	parameter int ITEM_SLOTS    = pic_pkg::ITEM_SLOTS_DEF,
	parameter int CLUSTER_SLOTS = pic_pkg::CLUSTER_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// pos_x, pos_y, pos_z, support_id, query_index, zero pad
	input  logic [pic_pkg::IN_DATA_W-1:0]      s_tdata,
	// operation
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// cluster_label, merged_count, cluster_total, item_total, zero pad
	output logic [pic_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status
	output logic [2:0]                         m_tuser,
	input  logic                               cfg_we,
	input  logic [0:0]                         cfg_index,
	input  logic [pic_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IW  = $clog2(ITEM_SLOTS);
	localparam int CW  = $clog2(ITEM_SLOTS + 1);
	localparam int LW  = $clog2(CLUSTER_SLOTS + 1);
	localparam int CIW = (CLUSTER_SLOTS > 1) ? $clog2(CLUSTER_SLOTS) : 1;
	localparam logic [LW-1:0] NO_LABEL = LW'(CLUSTER_SLOTS);

	pic_pkg::seq_state_t state_q, state_d;

	logic [pic_pkg::RANGE_W-1:0] cfg_range_q;
	logic [pic_pkg::LIMIT_W-1:0] cfg_limit_q;
	logic [CW-1:0]               item_count_q;
	logic [LW-1:0]               cl_count_q;
	logic                        m_tvalid_q;
	logic [pic_pkg::OUT_DATA_W-1:0] m_tdata_q;
	pic_pkg::status_t            m_tuser_q;

	pic_pkg::item_t              new_q;
	logic [IW-1:0]               j_q;
	pic_pkg::axis_t              ph_q;
	logic [CW-1:0]               t_q;
	logic [CLUSTER_SLOTS-1:0]    chit_q;
	logic [LW-1:0]               map_q [CLUSTER_SLOTS];
	logic [LW-1:0]               i_q, cnt_q, target_q;
	logic                        joined_q;
	logic [pic_pkg::MERGED_W-1:0] merged_q;
	pic_pkg::status_t            res_status_q;
	logic [LW-1:0]               res_label_q;

	logic                        in_fire, out_free, q_ok, last_j, hit, lim_full;
	pic_pkg::op_t                in_op;
	pic_pkg::item_t              in_item;
	logic [pic_pkg::QIDX_W-1:0]  in_q;
	logic [LW-1:0]               m_last, mapped;

	pic_pkg::item_t              pos_wdata, pos_rdata;
	logic                        pos_we, lab_we, near;
	logic [IW-1:0]               pos_waddr, pos_raddr, lab_waddr, lab_raddr;
	logic [LW-1:0]               lab_wdata, lab_rdata;
	pic_pkg::dist_ctl_t          dctl;

	// unpack the input word
	assign in_op       = pic_pkg::op_t'(s_tuser[0]);
	assign in_item.x   = s_tdata[15:0];
	assign in_item.y   = s_tdata[31:16];
	assign in_item.z   = s_tdata[47:32];
	assign in_item.sup = s_tdata[57:48];
	assign in_q        = s_tdata[65:58];

	assign s_tready = (state_q == pic_pkg::S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign q_ok     = (32'(in_q) < 32'(item_count_q));
	assign last_j   = (CW'(j_q) == item_count_q - CW'(1));
	assign hit      = near && (pos_rdata.sup == new_q.sup);
	assign m_last   = cnt_q - LW'(1);
	assign lim_full = (32'(cnt_q) >= 32'(cfg_limit_q)) ||
	                  (cnt_q >= NO_LABEL);
	assign mapped   = (lab_rdata < NO_LABEL) ? map_q[lab_rdata[CIW-1:0]] : lab_rdata;

	// memory ports
	always_comb begin
		pos_raddr = j_q;
		lab_raddr = j_q;
		case (state_q)
			pic_pkg::S_IDLE: begin
				pos_raddr = '0;
				lab_raddr = (in_op == pic_pkg::OP_QUERY) ? IW'(in_q) : '0;
			end
			pic_pkg::S_SCAN: begin
				if (ph_q == pic_pkg::AX_SUM) begin
					pos_raddr = j_q + IW'(1);
					lab_raddr = j_q + IW'(1);
				end
			end
			pic_pkg::S_RELAB: begin
				lab_raddr = t_q[IW-1:0];
			end
			default: begin
				pos_raddr = j_q;
			end
		endcase
	end

	assign pos_we    = (state_q == pic_pkg::S_STORE);
	assign pos_waddr = IW'(item_count_q);
	assign pos_wdata = new_q;
	assign lab_we    = (state_q == pic_pkg::S_STORE) ||
	                   ((state_q == pic_pkg::S_RELAB) && (t_q != '0));
	assign lab_waddr = (state_q == pic_pkg::S_STORE) ? IW'(item_count_q)
	                                                  : IW'(t_q - CW'(1));
	assign lab_wdata = (state_q == pic_pkg::S_STORE) ? res_label_q : mapped;

	assign dctl.axis = ph_q;
	assign dctl.clr  = (ph_q == pic_pkg::AX_Y);

	pic_store #(
		.ITEM_SLOTS (ITEM_SLOTS),
		.LW         (LW)
	) u_store (
		.clk       (clk),
		.pos_we    (pos_we),
		.pos_waddr (pos_waddr),
		.pos_wdata (pos_wdata),
		.pos_raddr (pos_raddr),
		.pos_rdata (pos_rdata),
		.lab_we    (lab_we),
		.lab_waddr (lab_waddr),
		.lab_wdata (lab_wdata),
		.lab_raddr (lab_raddr),
		.lab_rdata (lab_rdata)
	);

	pic_dist u_dist (
		.clk      (clk),
		.ctl      (dctl),
		.a        (new_q),
		.b        (pos_rdata),
		.range_sq (cfg_range_q),
		.near     (near)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pic_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pic_pkg::S_IDLE: begin
				if (in_fire) begin
					if (in_op == pic_pkg::OP_QUERY) begin
						state_d = q_ok ? pic_pkg::S_QREAD : pic_pkg::S_RESULT;
					end else if (32'(item_count_q) >= ITEM_SLOTS) begin
						state_d = pic_pkg::S_RESULT;
					end else if (item_count_q == '0) begin
						state_d = pic_pkg::S_MERGE;
					end else begin
						state_d = pic_pkg::S_SCAN;
					end
				end
			end
			pic_pkg::S_SCAN: begin
				if ((ph_q == pic_pkg::AX_SUM) && last_j) begin
					state_d = pic_pkg::S_MERGE;
				end
			end
			pic_pkg::S_MERGE: begin
				if (i_q >= cnt_q) begin
					state_d = (merged_q != '0) ? pic_pkg::S_RELAB : pic_pkg::S_STORE;
				end
			end
			pic_pkg::S_RELAB: begin
				if (t_q == item_count_q) begin
					state_d = pic_pkg::S_STORE;
				end
			end
			pic_pkg::S_STORE: state_d = pic_pkg::S_RESULT;
			pic_pkg::S_QREAD: state_d = pic_pkg::S_RESULT;
			pic_pkg::S_RESULT: begin
				if (out_free) begin
					state_d = pic_pkg::S_IDLE;
				end
			end
			default: state_d = pic_pkg::S_IDLE;
		endcase
	end

	// control state: config, counts, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_range_q  <= pic_pkg::RANGE_W'(16384);
			cfg_limit_q  <= pic_pkg::LIMIT_W'(32);
			item_count_q <= '0;
			cl_count_q   <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (pic_pkg::cfg_reg_t'(cfg_index))
					pic_pkg::REG_RANGE_SQ:      cfg_range_q <= cfg_data;
					pic_pkg::REG_CLUSTER_LIMIT: cfg_limit_q <= cfg_data[pic_pkg::LIMIT_W-1:0];
					default: cfg_range_q <= cfg_range_q;
				endcase
			end
			if (state_q == pic_pkg::S_STORE) begin
				item_count_q <= item_count_q + CW'(1);
				cl_count_q   <= cnt_q;
			end
			if ((state_q == pic_pkg::S_RESULT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		case (state_q)
			pic_pkg::S_IDLE: begin
				if (in_fire) begin
					new_q    <= in_item;
					j_q      <= '0;
					ph_q     <= pic_pkg::AX_X;
					t_q      <= '0;
					chit_q   <= '0;
					i_q      <= '0;
					cnt_q    <= cl_count_q;
					joined_q <= 1'b0;
					target_q <= '0;
					merged_q <= '0;
					for (int c = 0; c < CLUSTER_SLOTS; c++) begin
						map_q[c] <= LW'(c);
					end
					res_label_q <= NO_LABEL;
					if (in_op == pic_pkg::OP_QUERY) begin
						res_status_q <= q_ok ? pic_pkg::RS_QUERY_OK : pic_pkg::RS_QUERY_RANGE;
					end else begin
						res_status_q <= pic_pkg::RS_STORE_FULL;
					end
				end
			end
			pic_pkg::S_SCAN: begin
				case (ph_q)
					pic_pkg::AX_X: ph_q <= pic_pkg::AX_Y;
					pic_pkg::AX_Y: ph_q <= pic_pkg::AX_Z;
					pic_pkg::AX_Z: ph_q <= pic_pkg::AX_SUM;
					default: begin
						ph_q <= pic_pkg::AX_X;
						j_q  <= j_q + IW'(1);
						// mark the cluster of a matching stored item
						if (hit && (lab_rdata < NO_LABEL)) begin
							chit_q[lab_rdata[CIW-1:0]] <= 1'b1;
						end
					end
				endcase
			end
			pic_pkg::S_MERGE: begin
				if (i_q < cnt_q) begin
					if (!chit_q[i_q[CIW-1:0]]) begin
						i_q <= i_q + LW'(1);
					end else if (!joined_q) begin
						joined_q <= 1'b1;
						target_q <= i_q;
						i_q      <= i_q + LW'(1);
					end else begin
						// fold cluster i into target, move the last cluster into i
						for (int c = 0; c < CLUSTER_SLOTS; c++) begin
							if (map_q[c] == i_q) begin
								map_q[c] <= target_q;
							end else if (map_q[c] == m_last) begin
								map_q[c] <= i_q;
							end
						end
						chit_q[i_q[CIW-1:0]]    <= chit_q[m_last[CIW-1:0]];
						chit_q[m_last[CIW-1:0]] <= 1'b0;
						cnt_q    <= m_last;
						merged_q <= merged_q + pic_pkg::MERGED_W'(1);
					end
				end else if (joined_q) begin
					res_status_q <= pic_pkg::RS_JOINED;
					res_label_q  <= target_q;
				end else if (lim_full) begin
					res_status_q <= pic_pkg::RS_CLUSTERS_FULL;
					res_label_q  <= NO_LABEL;
				end else begin
					res_status_q <= pic_pkg::RS_NEW_CLUSTER;
					res_label_q  <= cnt_q;
					cnt_q        <= cnt_q + LW'(1);
				end
			end
			pic_pkg::S_RELAB: begin
				t_q <= t_q + CW'(1);
			end
			pic_pkg::S_QREAD: begin
				res_label_q <= lab_rdata;
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if ((state_q == pic_pkg::S_RESULT) && out_free) begin
			m_tdata_q <= {6'b0,
			              pic_pkg::ITOTAL_W'(item_count_q),
			              pic_pkg::CTOTAL_W'(cl_count_q),
			              (res_status_q == pic_pkg::RS_JOINED) ? merged_q
			                                                  : pic_pkg::MERGED_W'(0),
			              pic_pkg::LABEL_W'(res_label_q)};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
